// File: hw/rtl/box_association_matcher_assert.svh
// Assertion macros used by the checker file of the box association matcher.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef BOX_ASSOCIATION_MATCHER_ASSERT_SVH
`define BOX_ASSOCIATION_MATCHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BAM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bam_pkg
// Types, widths and codes shared by the box association matcher modules.
// ----------------------------------------------------------------------------
package bam_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int COORD_BITS  = 12;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int PTR_W       = $clog2(TABLE_DEPTH + 1);
    localparam int EDGE_W      = COORD_BITS + 1;
    localparam int INTER_W     = 2 * COORD_BITS;
    localparam int UNION_W     = 2 * COORD_BITS + 1;
    localparam int CEN_W       = COORD_BITS + 2;
    localparam int DSQ_W       = 2 * CEN_W + 1;
    localparam int THR_W       = 16;
    localparam int LIM_W       = 13;
    localparam int LIM2_W      = 2 * (LIM_W + 1);
    localparam int ID_W        = 16;
    localparam int CAT_W       = 8;
    localparam int DIST_W      = 16;
    localparam int PADDR_W     = 3;
    localparam int IOU_SHIFT   = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd16384;
    localparam logic [LIM_W-1:0] LIM_RESET = 13'd64;

    // Register select is the word address bit.
    localparam logic REG_IOU_THR    = 1'b0;
    localparam logic REG_CENTRE_LIM = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_MATCH = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_IOU    = 2'd1,
        KIND_CENTRE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
    } t_box;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CAT_W-1:0]  category;
        t_box              rect;
        logic [DIST_W-1:0] distance;
    } t_slot;

    // Control that travels with each table read.
    typedef struct packed {
        logic              beat;
        logic              last;
        logic              hit;
        logic [ADDR_W-1:0] idx;
    } t_tag;

    // Per-slot result of the scoring pipeline.
    typedef struct packed {
        logic               beat;
        logic               last;
        logic [ADDR_W-1:0]  idx;
        logic               iou_pass;
        logic               dist_pass;
        logic [INTER_W-1:0] inter;
        logic [UNION_W-1:0] uni;
        logic [DSQ_W-1:0]   dsq;
        logic [ID_W-1:0]    id;
        logic [DIST_W-1:0]  distance;
    } t_score;

endpackage
`default_nettype wire

// File: hw/rtl/bam_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bam_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module bam_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/bam_score.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bam_score
// Four-stage pipeline that scores one table entry against the new box.
// ----------------------------------------------------------------------------
module bam_score (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bam_pkg::t_tag                  i_tag,
    input  wire bam_pkg::t_slot                 i_slot,
    input  wire bam_pkg::t_box                  i_box,
    input  wire logic [bam_pkg::CAT_W-1:0]      i_cat,
    input  wire logic [bam_pkg::INTER_W-1:0]    i_area_new,
    input  wire logic [bam_pkg::THR_W-1:0]      i_thr,
    input  wire logic [bam_pkg::LIM2_W-1:0]     i_lim2,
    output bam_pkg::t_score                     o_score
);
    import bam_pkg::*;

    // Stage 1: overlap extents and centroid offsets.
    logic [EDGE_W-1:0] x1, y1, x2, y2, nx2, ny2, ox2, oy2;
    logic [CEN_W-1:0]  ncx, ncy, ocx, ocy;
    logic [COORD_BITS-1:0] ix, iy;
    logic [CEN_W-1:0]  dx, dy;
    logic              hit;

    always_comb begin
        nx2 = EDGE_W'(i_box.x) + EDGE_W'(i_box.w);
        ny2 = EDGE_W'(i_box.y) + EDGE_W'(i_box.h);
        ox2 = EDGE_W'(i_slot.rect.x) + EDGE_W'(i_slot.rect.w);
        oy2 = EDGE_W'(i_slot.rect.y) + EDGE_W'(i_slot.rect.h);
        x1  = (i_box.x > i_slot.rect.x) ? EDGE_W'(i_box.x) : EDGE_W'(i_slot.rect.x);
        y1  = (i_box.y > i_slot.rect.y) ? EDGE_W'(i_box.y) : EDGE_W'(i_slot.rect.y);
        x2  = (nx2 < ox2) ? nx2 : ox2;
        y2  = (ny2 < oy2) ? ny2 : oy2;
        // The intersection extent never exceeds either box's own size.
        ix  = (x2 > x1 && y2 > y1) ? COORD_BITS'(x2 - x1) : '0;
        iy  = (x2 > x1 && y2 > y1) ? COORD_BITS'(y2 - y1) : '0;
        ncx = {1'b0, i_box.x, 1'b0} + CEN_W'(i_box.w);
        ncy = {1'b0, i_box.y, 1'b0} + CEN_W'(i_box.h);
        ocx = {1'b0, i_slot.rect.x, 1'b0} + CEN_W'(i_slot.rect.w);
        ocy = {1'b0, i_slot.rect.y, 1'b0} + CEN_W'(i_slot.rect.h);
        dx  = (ncx > ocx) ? ncx - ocx : ocx - ncx;
        dy  = (ncy > ocy) ? ncy - ocy : ocy - ncy;
        hit = i_tag.hit && (i_slot.category == i_cat);
    end

    t_tag                  r_s1_tag;
    logic                  r_s1_hit;
    logic [COORD_BITS-1:0] r_s1_ix, r_s1_iy, r_s1_ow, r_s1_oh;
    logic [CEN_W-1:0]      r_s1_dx, r_s1_dy;
    logic [ID_W-1:0]       r_s1_id;
    logic [DIST_W-1:0]     r_s1_dist;

    // Stage 2: products.
    t_tag                  r_s2_tag;
    logic                  r_s2_hit;
    logic [INTER_W-1:0]    r_s2_inter, r_s2_area;
    logic [2*CEN_W-1:0]    r_s2_dxs, r_s2_dys;
    logic [ID_W-1:0]       r_s2_id;
    logic [DIST_W-1:0]     r_s2_dist;

    // Stage 3: union and squared distance.
    t_tag                  r_s3_tag;
    logic                  r_s3_hit;
    logic [INTER_W-1:0]    r_s3_inter;
    logic [UNION_W-1:0]    r_s3_uni;
    logic [DSQ_W-1:0]      r_s3_dsq;
    logic [ID_W-1:0]       r_s3_id;
    logic [DIST_W-1:0]     r_s3_dist;

    logic [THR_W+UNION_W-1:0] thr_prod;
    logic [THR_W+UNION_W-1:0] inter_scaled;

    assign thr_prod     = (THR_W+UNION_W)'(i_thr) * (THR_W+UNION_W)'(r_s3_uni);
    assign inter_scaled = (THR_W+UNION_W)'({r_s3_inter, {IOU_SHIFT{1'b0}}});

    always_ff @(posedge i_clk) begin
        // Only the beat flags are reset; the payload follows them.
        if (!i_rst_n) begin
            r_s1_tag.beat  <= 1'b0;
            r_s2_tag.beat  <= 1'b0;
            r_s3_tag.beat  <= 1'b0;
            o_score.beat   <= 1'b0;
        end else begin
            r_s1_tag.beat  <= i_tag.beat;
            r_s2_tag.beat  <= r_s1_tag.beat;
            r_s3_tag.beat  <= r_s2_tag.beat;
            o_score.beat   <= r_s3_tag.beat;
        end

        r_s1_tag.last <= i_tag.last;
        r_s1_tag.hit  <= i_tag.hit;
        r_s1_tag.idx  <= i_tag.idx;
        r_s1_hit      <= hit;
        r_s1_ix       <= ix;
        r_s1_iy       <= iy;
        r_s1_ow       <= i_slot.rect.w;
        r_s1_oh       <= i_slot.rect.h;
        r_s1_dx       <= dx;
        r_s1_dy       <= dy;
        r_s1_id       <= i_slot.id;
        r_s1_dist     <= i_slot.distance;

        r_s2_tag.last <= r_s1_tag.last;
        r_s2_tag.hit  <= r_s1_tag.hit;
        r_s2_tag.idx  <= r_s1_tag.idx;
        r_s2_hit      <= r_s1_hit;
        r_s2_inter    <= INTER_W'(r_s1_ix) * INTER_W'(r_s1_iy);
        r_s2_area     <= INTER_W'(r_s1_ow) * INTER_W'(r_s1_oh);
        r_s2_dxs      <= (2*CEN_W)'(r_s1_dx) * (2*CEN_W)'(r_s1_dx);
        r_s2_dys      <= (2*CEN_W)'(r_s1_dy) * (2*CEN_W)'(r_s1_dy);
        r_s2_id       <= r_s1_id;
        r_s2_dist     <= r_s1_dist;

        r_s3_tag.last <= r_s2_tag.last;
        r_s3_tag.hit  <= r_s2_tag.hit;
        r_s3_tag.idx  <= r_s2_tag.idx;
        r_s3_hit      <= r_s2_hit;
        r_s3_inter    <= r_s2_inter;
        r_s3_uni      <= UNION_W'(i_area_new) + UNION_W'(r_s2_area) - UNION_W'(r_s2_inter);
        r_s3_dsq      <= DSQ_W'(r_s2_dxs) + DSQ_W'(r_s2_dys);
        r_s3_id       <= r_s2_id;
        r_s3_dist     <= r_s2_dist;

        // Stage 4: threshold tests, exact by cross-multiplication.
        o_score.last      <= r_s3_tag.last;
        o_score.idx       <= r_s3_tag.idx;
        o_score.iou_pass  <= r_s3_hit && (r_s3_uni != '0) && (inter_scaled > thr_prod);
        o_score.dist_pass <= r_s3_hit && (DSQ_W'(r_s3_dsq) < DSQ_W'(i_lim2));
        o_score.inter     <= r_s3_inter;
        o_score.uni       <= r_s3_uni;
        o_score.dsq       <= r_s3_dsq;
        o_score.id        <= r_s3_id;
        o_score.distance  <= r_s3_dist;
    end

endmodule
`default_nettype wire

// File: hw/rtl/box_association_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Clear and load items apply on acceptance, one per cycle while idle; a match
// item raises its result once its scan has passed the scoring pipeline.
// Throughput: a match holds off new items until done, as the scan reads one slot
// per cycle over the single read port of the slot memory.
// Reset: synchronous, active low; clears all valid bits, the load pointer,
// the state machine and restores the configuration registers to defaults.
// ----------------------------------------------------------------------------
// box_association_matcher
// Matches a new box against a table of tracked boxes by best IoU, falling
// back to nearest centroid, and removes the matched entry from the table.
// ----------------------------------------------------------------------------
module box_association_matcher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input item stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata, low bit up: object_id[15:0], category[23:16], box_x[35:24],
    // box_y[47:36], box_width[59:48], box_height[71:60], distance_value[87:72]
    input  wire logic [87:0] s_axis_tdata,
    // tuser: command[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // Result item stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata, low bit up: matched_id[15:0], distance_prev[31:16]
    output logic      [31:0] m_axis_tdata,
    // tuser: match_kind[1:0]
    output logic      [1:0]  m_axis_tuser,
    // Configuration port.
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bam_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import bam_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land at the access phase; write them only
    // between items, as the block itself does not enforce this.
    // ------------------------------------------------------------------
    logic [THR_W-1:0] r_thr;
    logic [LIM_W-1:0] r_lim;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_lim <= LIM_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_IOU_THR:    r_thr <= pwdata[THR_W-1:0];
                REG_CENTRE_LIM: r_lim <= pwdata[LIM_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IOU_THR:    prdata = 32'(r_thr);
            REG_CENTRE_LIM: prdata = 32'(r_lim);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input field unpacking.
    // ------------------------------------------------------------------
    t_slot in_slot;
    logic  in_acc;
    logic  is_clear, is_load, is_match;

    assign in_slot.id          = s_axis_tdata[15:0];
    assign in_slot.category    = s_axis_tdata[23:16];
    assign in_slot.rect.x      = s_axis_tdata[35:24];
    assign in_slot.rect.y      = s_axis_tdata[47:36];
    assign in_slot.rect.w      = s_axis_tdata[59:48];
    assign in_slot.rect.h      = s_axis_tdata[71:60];
    assign in_slot.distance    = s_axis_tdata[87:72];

    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        is_clear = 1'b0;
        is_load  = 1'b0;
        is_match = 1'b0;
        unique case (s_axis_tuser)
            CMD_CLEAR: is_clear = 1'b1;
            CMD_LOAD:  is_load  = 1'b1;
            CMD_MATCH: is_match = 1'b1;
            default:   ;  // the spare code is ignored
        endcase
    end

    // ------------------------------------------------------------------
    // Control state machine.
    // ------------------------------------------------------------------
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              scan_last;
    logic              out_free;
    t_score            score;

    assign scan_last     = (r_addr == ADDR_W'(TABLE_DEPTH - 1));
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && is_match) begin
                    n_state = ST_SCAN;
                    n_addr  = '0;
                end
            end
            ST_SCAN: begin
                n_addr = r_addr + 1'b1;
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (score.beat && score.last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Slot table: payload in memory, valid bits in flops so a clear resets
    // all of them together. Removed slots stay unused until the next clear.
    // ------------------------------------------------------------------
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [PTR_W-1:0]       r_ptr;
    logic                   load_ok;
    logic                   found_iou, found_dist, finish;
    logic [ADDR_W-1:0]      sel_idx;
    t_slot                  rd_slot;

    logic                   r_iou_found, r_dist_found;
    logic [ADDR_W-1:0]      r_iou_idx, r_dist_idx;

    assign load_ok = (r_ptr < PTR_W'(TABLE_DEPTH));
    assign finish  = (r_state == ST_DONE) && out_free;
    assign sel_idx = r_iou_found ? r_iou_idx : r_dist_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else if (in_acc && is_clear) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else if (in_acc && is_load && load_ok) begin
            r_valid[r_ptr[ADDR_W-1:0]] <= 1'b1;
            r_ptr                      <= r_ptr + 1'b1;
        end else if (finish && (r_iou_found || r_dist_found)) begin
            r_valid[sel_idx] <= 1'b0;
        end
    end

    bam_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH ($bits(t_slot))
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && is_load && load_ok),
        .i_wr_addr (r_ptr[ADDR_W-1:0]),
        .i_wr_data (in_slot),
        .i_rd_en   (r_state == ST_SCAN),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_slot)
    );

    // The tag is registered alongside the memory read so both line up.
    t_tag r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.beat <= 1'b0;
        end else begin
            r_tag.beat <= (r_state == ST_SCAN);
        end
        r_tag.last <= scan_last;
        r_tag.hit  <= r_valid[r_addr];
        r_tag.idx  <= r_addr;
    end

    // ------------------------------------------------------------------
    // New box context, latched when a match item is accepted. The new box
    // area and the squared doubled distance limit are computed once here.
    // ------------------------------------------------------------------
    t_box               r_box;
    logic [CAT_W-1:0]   r_cat;
    logic [INTER_W-1:0] r_area_new;
    logic [LIM2_W-1:0]  r_lim2;
    logic [LIM_W:0]     lim_x2;

    assign lim_x2 = {r_lim, 1'b0};

    always_ff @(posedge i_clk) begin
        if (in_acc && is_match) begin
            r_box      <= in_slot.rect;
            r_cat      <= in_slot.category;
            r_area_new <= INTER_W'(in_slot.rect.w) * INTER_W'(in_slot.rect.h);
            r_lim2     <= LIM2_W'(lim_x2) * LIM2_W'(lim_x2);
        end
    end

    bam_score u_score (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tag      (r_tag),
        .i_slot     (rd_slot),
        .i_box      (r_box),
        .i_cat      (r_cat),
        .i_area_new (r_area_new),
        .i_thr      (r_thr),
        .i_lim2     (r_lim2),
        .o_score    (score)
    );

    // ------------------------------------------------------------------
    // Best-candidate tracking. Both the IoU and the centroid winners are
    // followed in the same scan; IoU wins at the end if it found anything.
    // Strict comparisons keep the lowest slot on ties.
    // ------------------------------------------------------------------
    logic [INTER_W-1:0]         r_bi;
    logic [UNION_W-1:0]         r_bu;
    logic [DSQ_W-1:0]           r_bd;
    logic [ID_W-1:0]            r_iou_id, r_dist_id;
    logic [DIST_W-1:0]          r_iou_dv, r_dist_dv;
    logic [INTER_W+UNION_W-1:0] lhs, rhs;

    assign lhs        = (INTER_W+UNION_W)'(score.inter) * (INTER_W+UNION_W)'(r_bu);
    assign rhs        = (INTER_W+UNION_W)'(r_bi) * (INTER_W+UNION_W)'(score.uni);
    assign found_iou  = score.beat && score.iou_pass && (!r_iou_found || lhs > rhs);
    assign found_dist = score.beat && score.dist_pass && (!r_dist_found || score.dsq < r_bd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iou_found  <= 1'b0;
            r_dist_found <= 1'b0;
        end else if (in_acc && is_match) begin
            r_iou_found  <= 1'b0;
            r_dist_found <= 1'b0;
        end else begin
            if (found_iou) begin
                r_iou_found <= 1'b1;
            end
            if (found_dist) begin
                r_dist_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (found_iou) begin
            r_bi      <= score.inter;
            r_bu      <= score.uni;
            r_iou_idx <= score.idx;
            r_iou_id  <= score.id;
            r_iou_dv  <= score.distance;
        end
        if (found_dist) begin
            r_bd       <= score.dsq;
            r_dist_idx <= score.idx;
            r_dist_id  <= score.id;
            r_dist_dv  <= score.distance;
        end
    end

    // ------------------------------------------------------------------
    // Output register. It holds a finished result while the next item is
    // accepted; a later match waits in ST_DONE until it is taken.
    // ------------------------------------------------------------------
    logic [1:0]        r_m_kind;
    logic [ID_W-1:0]   r_m_id;
    logic [DIST_W-1:0] r_m_dist;
    logic              r_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (finish) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (r_iou_found) begin
                r_m_kind <= KIND_IOU;
                r_m_id   <= r_iou_id;
                r_m_dist <= r_iou_dv;
            end else if (r_dist_found) begin
                r_m_kind <= KIND_CENTRE;
                r_m_id   <= r_dist_id;
                r_m_dist <= r_dist_dv;
            end else begin
                r_m_kind <= KIND_NONE;
                r_m_id   <= '0;
                r_m_dist <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tdata  = {r_m_dist, r_m_id};

endmodule
`default_nettype wire

// File: hw/rtl/bam_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bam_checker
// Port-level checks on the result stream of the box association matcher.
// ----------------------------------------------------------------------------
`include "box_association_matcher_assert.svh"

module bam_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);
    import bam_pkg::*;

    `BAM_ASSERT_IMPLY(a_kind_legal, m_axis_tvalid, (m_axis_tuser == KIND_NONE) || (m_axis_tuser == KIND_IOU) || (m_axis_tuser == KIND_CENTRE), "match kind out of range")
    `BAM_ASSERT_IMPLY(a_nomatch_zero, m_axis_tvalid && (m_axis_tuser == KIND_NONE), m_axis_tdata == '0, "no-match result carries data")
    `BAM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    `BAM_ASSERT_IMPLY(a_reset_empty, !$past(i_rst_n), !m_axis_tvalid, "result valid right after reset")

endmodule

bind box_association_matcher bam_checker u_bam_checker (.*);
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box association matcher. Table loads, clears
// and match requests are streamed in with random gaps, results are pulled out
// with random back-pressure, and every result is compared with a predictor
// that keeps its own copy of the slot table and the two thresholds.
// ----------------------------------------------------------------------------
module tb_top;
    import bam_pkg::*;

    localparam int N_RANDOM   = 1300;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] id;
        logic [7:0]  cat;
        logic [11:0] x, y, w, h;
        logic [15:0] distance;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] id;
        logic [15:0] distance;
    } t_match;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    box_association_matcher dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Predictor state: a private copy of the slot table and registers.
    logic        tbl_valid [TABLE_DEPTH];
    logic [15:0] tbl_id    [TABLE_DEPTH];
    logic [7:0]  tbl_cat   [TABLE_DEPTH];
    logic [11:0] tbl_x [TABLE_DEPTH], tbl_y [TABLE_DEPTH];
    logic [11:0] tbl_w [TABLE_DEPTH], tbl_h [TABLE_DEPTH];
    logic [15:0] tbl_dist  [TABLE_DEPTH];
    int          load_ptr;
    logic [15:0] iou_thr;
    logic [12:0] centre_lim;

    t_req   pending_reqs[$];
    t_match expected_matches[$];
    int     mismatches = 0;
    bit     calm = 1'b0;   // the last part of the run has no idling
    bit     stim_done = 1'b0;

    // Works out the effect of one accepted item; pushes a result for a match.
    task automatic predict_item(input t_req r);
        longint unsigned ix1, iy1, ix2, iy2, inter, uni, bi, bu, d, bd, lim2;
        longint unsigned cx, cy;
        int best;
        t_match m;
        best = -1;
        bi = 0;
        bu = 1;
        bd = 0;
        case (r.cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
                load_ptr = 0;
            end
            CMD_LOAD: begin
                if (load_ptr < TABLE_DEPTH) begin
                    tbl_valid[load_ptr] = 1'b1;
                    tbl_id[load_ptr] = r.id;
                    tbl_cat[load_ptr] = r.cat;
                    tbl_x[load_ptr] = r.x;
                    tbl_y[load_ptr] = r.y;
                    tbl_w[load_ptr] = r.w;
                    tbl_h[load_ptr] = r.h;
                    tbl_dist[load_ptr] = r.distance;
                    load_ptr++;
                end
            end
            CMD_MATCH: begin
                // Best IoU pass: rationals compared by cross-multiplication.
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (tbl_valid[i] && tbl_cat[i] == r.cat) begin
                        ix1 = (r.x > tbl_x[i]) ? r.x : tbl_x[i];
                        iy1 = (r.y > tbl_y[i]) ? r.y : tbl_y[i];
                        ix2 = (longint'(r.x) + r.w < longint'(tbl_x[i]) + tbl_w[i]) ?
                              longint'(r.x) + r.w : longint'(tbl_x[i]) + tbl_w[i];
                        iy2 = (longint'(r.y) + r.h < longint'(tbl_y[i]) + tbl_h[i]) ?
                              longint'(r.y) + r.h : longint'(tbl_y[i]) + tbl_h[i];
                        inter = (ix2 > ix1 && iy2 > iy1) ? (ix2 - ix1) * (iy2 - iy1) : 0;
                        uni = longint'(r.w) * r.h + longint'(tbl_w[i]) * tbl_h[i] - inter;
                        if (uni != 0 && inter * 65536 > longint'(iou_thr) * uni &&
                            (best < 0 || inter * bu > bi * uni)) begin
                            best = i;
                            bi = inter;
                            bu = uni;
                        end
                    end
                end
                m.kind = (best >= 0) ? KIND_IOU : KIND_NONE;
                if (best < 0) begin
                    // Fallback: nearest centroid at doubled scale.
                    lim2 = 4 * longint'(centre_lim) * centre_lim;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (tbl_valid[i] && tbl_cat[i] == r.cat) begin
                            cx = 2 * longint'(r.x) + r.w;
                            d = 2 * longint'(tbl_x[i]) + tbl_w[i];
                            cx = (cx > d) ? cx - d : d - cx;
                            cy = 2 * longint'(r.y) + r.h;
                            d = 2 * longint'(tbl_y[i]) + tbl_h[i];
                            cy = (cy > d) ? cy - d : d - cy;
                            d = cx * cx + cy * cy;
                            if (d < lim2 && (best < 0 || d < bd)) begin
                                best = i;
                                bd = d;
                            end
                        end
                    end
                    if (best >= 0) m.kind = KIND_CENTRE;
                end
                if (best >= 0) begin
                    m.id = tbl_id[best];
                    m.distance = tbl_dist[best];
                    tbl_valid[best] = 1'b0;
                end else begin
                    m.id = '0;
                    m.distance = '0;
                end
                expected_matches.push_back(m);
            end
            default: ;   // command three is ignored
        endcase
    endtask

    // Driver: presents queued items with random gaps.
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) predict_item(pending_reqs.pop_front());
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if ((s_axis_tvalid && s_axis_tready ? pending_reqs.size() > 0 :
                              pending_reqs.size() > 0)) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        src_gap <= $urandom_range(0, 8);
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        s_axis_tvalid <= 1'b1;
                        s_axis_tuser <= pending_reqs[0].cmd;
                        s_axis_tdata <= {pending_reqs[0].distance, pending_reqs[0].h,
                                         pending_reqs[0].w, pending_reqs[0].y,
                                         pending_reqs[0].x, pending_reqs[0].cat,
                                         pending_reqs[0].id};
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and comparison against the oldest expectation.
    int sink_gap = 0;
    always @(posedge i_clk) begin
        t_match exp_m;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_matches.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind=%0d id=%0d dist=%0d",
                                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]);
                end else begin
                    exp_m = expected_matches.pop_front();
                    if (m_axis_tuser !== exp_m.kind || m_axis_tdata[15:0] !== exp_m.id ||
                        m_axis_tdata[31:16] !== exp_m.distance) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: exp kind=%0d id=%0d dist=%0d, got %0d %0d %0d",
                                     exp_m.kind, exp_m.id, exp_m.distance, m_axis_tuser,
                                     m_axis_tdata[15:0], m_axis_tdata[31:16]);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                sink_gap <= $urandom_range(0, 8);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles in which nothing is accepted on either stream.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic t_req make_req(logic [1:0] cmd, logic [7:0] cat,
                                      logic [11:0] x, logic [11:0] y,
                                      logic [11:0] w, logic [11:0] h);
        t_req r;
        r.cmd = cmd;
        r.id = 16'($urandom);
        r.cat = cat;
        r.x = x;
        r.y = y;
        r.w = w;
        r.h = h;
        r.distance = 16'($urandom);
        return r;
    endfunction

    // Jittered copy of a box, for near matches.
    function automatic logic [11:0] jitter(logic [11:0] v, int span);
        int t;
        t = int'(v) + $urandom_range(0, 2 * span) - span;
        if (t < 0) t = 0;
        if (t > 4095) t = 4095;
        return 12'(t);
    endfunction

    // One tracking frame: clear, load some boxes, then mostly match perturbed copies.
    task automatic queue_frame();
        t_req olds[$];
        t_req r;
        int n;
        n = $urandom_range(1, 34);   // sometimes beyond the table depth
        pending_reqs.push_back(make_req(CMD_CLEAR, 0, 0, 0, 0, 0));
        for (int i = 0; i < n; i++) begin
            r = make_req(CMD_LOAD, 8'($urandom_range(0, 3)), 12'($urandom_range(0, 3000)),
                         12'($urandom_range(0, 3000)), 12'($urandom_range(0, 300)),
                         12'($urandom_range(0, 300)));
            if ($urandom_range(0, 20) == 0) r = make_req(CMD_LOAD, 8'($urandom),
                12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
            olds.push_back(r);
            pending_reqs.push_back(r);
        end
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: r = make_req(CMD_MATCH, 8'($urandom), 12'($urandom), 12'($urandom),
                                12'($urandom), 12'($urandom));
                1: r = make_req(2'd3, 8'($urandom), 12'($urandom), 12'($urandom),
                                12'($urandom), 12'($urandom));
                default: begin
                    r = olds[$urandom_range(0, olds.size() - 1)];
                    r.cmd = CMD_MATCH;
                    r.x = jitter(r.x, 40);
                    r.y = jitter(r.y, 40);
                    r.w = jitter(r.w, 20);
                    r.h = jitter(r.h, 20);
                end
            endcase
            pending_reqs.push_back(r);
        end
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until the block has drained, then writes both thresholds.
    task automatic set_thresholds(logic [15:0] thr, logic [12:0] lim);
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_matches.size() > 0)
            @(posedge i_clk);
        repeat (TABLE_DEPTH + 10) @(posedge i_clk);
        apb_write({REG_IOU_THR, 2'b00}, {16'h0, thr});
        apb_write({REG_CENTRE_LIM, 2'b00}, {19'h0, lim});
        iou_thr = thr;
        centre_lim = lim;
    endtask

    initial begin
        t_req r;
        for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
        load_ptr = 0;
        iou_thr = THR_RESET;
        centre_lim = LIM_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every command, empty and full-size boxes.
        pending_reqs.push_back(make_req(CMD_MATCH, 8'd0, 0, 0, 0, 0));  // empty table
        pending_reqs.push_back(make_req(CMD_LOAD, 8'd255, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
        pending_reqs.push_back(make_req(CMD_LOAD, 8'd0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_LOAD, 8'd7, 100, 100, 50, 50));
        pending_reqs.push_back(make_req(CMD_LOAD, 8'd7, 100, 100, 50, 50));   // tie
        pending_reqs.push_back(make_req(2'd3, 8'd7, 100, 100, 50, 50));
        pending_reqs.push_back(make_req(CMD_MATCH, 8'd7, 100, 100, 50, 50));  // lowest slot
        pending_reqs.push_back(make_req(CMD_MATCH, 8'd7, 110, 110, 0, 0));    // zero area
        pending_reqs.push_back(make_req(CMD_MATCH, 8'd255, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
        pending_reqs.push_back(make_req(CMD_MATCH, 8'd0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_MATCH, 8'd7, 100, 100, 50, 50));  // table spent
        r = make_req(CMD_LOAD, 8'hAA, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
        r.id = 16'hFFFF;
        r.distance = 16'hFFFF;
        pending_reqs.push_back(r);
        r.cmd = CMD_MATCH;
        pending_reqs.push_back(r);
        for (int i = 0; i < 35; i++)   // fills the table past its depth
            pending_reqs.push_back(make_req(CMD_LOAD, 8'd1, 12'(i * 8), 0, 4, 4));
        pending_reqs.push_back(make_req(CMD_MATCH, 8'd1, 0, 0, 4, 4));
        pending_reqs.push_back(make_req(CMD_CLEAR, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(CMD_MATCH, 8'd1, 0, 0, 4, 4));

        // Random frames under several threshold settings, extremes included.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_thresholds(16'd0, 13'd8191);
                1: set_thresholds(16'hFFFF, 13'd0);
                2: set_thresholds(16'd16384, 13'd64);
                3: set_thresholds(16'($urandom), 13'($urandom_range(1, 200)));
                default: set_thresholds(16'd32768, 13'd20);
            endcase
            if (phase == 4) calm = 1'b1;
            for (int k = 0; k < N_RANDOM / 5; k += 0) begin
                queue_frame();
                k = N_RANDOM / 5 - (N_RANDOM / 5 - k) + 40;
                while (pending_reqs.size() > 100) @(posedge i_clk);
            end
        end

        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_matches.size() > 0)
            @(posedge i_clk);
        repeat (TABLE_DEPTH + 20) @(posedge i_clk);
        if (mismatches == 0 && expected_matches.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/bam_pkg.sv
hw/rtl/bam_ram.sv
hw/rtl/bam_score.sv
hw/rtl/box_association_matcher.sv
hw/rtl/bam_checker.sv
tb/tb_top.sv
